// ===== hw/rtl/kuwahara_gray_filter_defines.svh =====
// Assertion macros shared by the Kuwahara filter RTL.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef KUWAHARA_GRAY_FILTER_DEFINES_SVH
`define KUWAHARA_GRAY_FILTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check that is switched off while reset is active.
`define KGF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that also holds while reset is active.
`define KGF_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KGF_ASSERT(lbl, prop, msg)
`define KGF_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/kgf_pkg.sv =====
// Shared types and constants for the Kuwahara gray filter.
// No dependencies; used by kgf_cell, the top level and the testbench.
package kgf_pkg;

    localparam int PIX_W      = 8;
    localparam int RAD_W      = 3;
    localparam int LW_W       = 11;
    localparam int FH_W       = 12;
    localparam int CCOL_W     = 10;
    localparam int CROW_W     = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int OUT_DATA_W = 32;
    localparam int NQUAD      = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

    // register reset values
    localparam logic [RAD_W-1:0] RADIUS_RESET = 3'd1;
    localparam logic [LW_W-1:0]  LW_RESET     = 11'd640;
    localparam logic [FH_W-1:0]  FH_RESET     = 12'd480;

    // quadrant order: upper-left, lower-left, upper-right, lower-right
    localparam logic [1:0] QUAD_LAST = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_LOAD,
        ST_SUM,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DISP,
        ST_PICK,
        ST_OUT
    } kgf_state_t;

    // controls of one window row cell
    typedef struct packed {
        logic shift;   // take a new column into the live window
        logic load;    // copy live window into the scan chain
        logic rotate;  // move the scan chain one place
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/kgf_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module kgf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/kgf_cell.sv =====
// One window row cell: live shift row plus a scan row that rotates along the chain.
// Depends on kgf_pkg.
module kgf_cell #(
    parameter int WIN = 9
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  kgf_pkg::cell_ctrl_t      ctrl,
    input  logic [kgf_pkg::PIX_W-1:0] pix_in,
    input  logic [kgf_pkg::PIX_W-1:0] scan_in,
    output logic [kgf_pkg::PIX_W-1:0] scan_out
);
    import kgf_pkg::*;

    logic [PIX_W-1:0] live_reg [WIN];
    logic [PIX_W-1:0] scan_reg [WIN];

    // live row: newest column at index 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN; i++)
            begin
                live_reg[i] <= '0;
            end
        end
        else if (ctrl.shift)
        begin
            live_reg[0] <= pix_in;
            for (int i = 1; i < WIN; i++)
            begin
                live_reg[i] <= live_reg[i-1];
            end
        end
    end

    // scan row: snapshot, then hands one pixel a cycle to the previous cell while rotate is set
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            for (int i = 0; i < WIN; i++)
            begin
                scan_reg[i] <= live_reg[i];
            end
        end
        else if (ctrl.rotate)
        begin
            for (int i = 0; i < WIN - 1; i++)
            begin
                scan_reg[i] <= scan_reg[i+1];
            end
            scan_reg[WIN-1] <= scan_in;
        end
    end

    assign scan_out = scan_reg[0];

endmodule

// ===== hw/rtl/kgf_div.sv =====
// Restoring divider, one quotient bit per cycle.
// No dependencies.
module kgf_div #(
    parameter int DVD_W = 13,
    parameter int DSR_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg;
    logic [DSR_W:0]   rem_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DSR_W:0]   trial;
    logic             fits;

    // trial subtraction of the next partial remainder
    always_comb
    begin
        trial = {rem_reg[DSR_W-1:0], quo_reg[DVD_W-1]};
        fits  = trial >= {1'b0, dsr_reg};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend shifts out, quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? (trial - {1'b0, dsr_reg}) : trial;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/kuwahara_gray_filter.sv =====
// Kuwahara gray filter, top level. Depends on kgf_pkg, kgf_ram, kgf_cell, kgf_div.
// Pixels arrive in raster order, one per input transaction, and each gives one result for the
// center pixel r rows up and r columns left. The line store is 2*MAX_RADIUS RAMs of MAX_WIDTH
// bytes, not cleared at reset. For a pixel whose window fits, the window snapshot circulates
// twice through the chain of row cells (sum pass, dispersion pass) and the four quadrant means
// share one bit-serial divider. A border pixel goes from the shift state straight to output.
// One item is in work at a time; a finished result waits in the output register while the
// next is taken.
`include "kuwahara_gray_filter_defines.svh"
module kuwahara_gray_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // config write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [kgf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kgf_pkg::CFG_DATA_W-1:0]     cfg_data,
    // pixel input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [kgf_pkg::PIX_W-1:0]          s_tdata,  // [7:0] gray_pixel
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] filtered_value, [17:8] center_column, [29:18] center_row, [31:30] zero
    output logic [kgf_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [0:0]                         m_tuser,  // [0] center_valid
    output logic                               m_tlast   // frame_end
);
    import kgf_pkg::*;

    localparam int SLOTS = 2 * MAX_RADIUS;
    localparam int WIN   = SLOTS + 1;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int SLW   = $clog2(SLOTS);
    localparam int AW    = $clog2(WIN);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int NMAX  = (MAX_RADIUS + 1) * (MAX_RADIUS + 1);
    localparam int NW    = $clog2(NMAX + 1);
    localparam int SUM_W = $clog2(NMAX * 255 + 1);
    localparam int DSP_W = $clog2(NMAX * 255 * 255 + 1);

    // configuration registers
    logic [RAD_W-1:0] radius_reg;
    logic [LW_W-1:0]  line_width_reg;
    logic [FH_W-1:0]  frame_height_reg;

    // control state
    kgf_state_t       state_reg, state_next;
    logic [CW-1:0]    col_reg;
    logic [FH_W-1:0]  row_reg;
    logic [SLW-1:0]   slot_reg;
    logic [AW-1:0]    a_cnt_reg;
    logic [AW-1:0]    b_cnt_reg;
    logic [1:0]       q_idx_reg;
    logic             m_tvalid_reg;

    // payload
    logic [PIX_W-1:0]  pix_reg;
    logic [NW-1:0]     n_reg;
    logic [SUM_W-1:0]  sum_reg  [NQUAD];
    logic [PIX_W-1:0]  mean_reg [NQUAD];
    logic [DSP_W-1:0]  disp_reg [NQUAD];
    logic [PIX_W-1:0]  res_mean_reg;
    logic              res_valid_reg;
    logic [CCOL_W-1:0] res_ccol_reg;
    logic [CROW_W-1:0] res_crow_reg;
    logic              res_last_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic              out_user_reg;
    logic              out_last_reg;

    // combinational
    logic [RW-1:0]     r_eff;
    logic [WW-1:0]     w_eff;
    logic [FH_W-1:0]   h_eff;
    logic              col_wrap;
    logic              row_wrap;
    logic              center_ok;
    logic              accept;
    logic              out_free;
    logic              pass_last;
    logic [PIX_W-1:0]  ram_rdata [SLOTS];
    logic [PIX_W-1:0]  row_in    [WIN];
    logic [PIX_W-1:0]  scan_out  [WIN];
    logic [PIX_W-1:0]  tap;
    logic [NQUAD-1:0]  qmask;
    cell_ctrl_t        cell_ctrl;
    logic              ram_we;
    logic              div_start;
    logic              div_done;
    logic [SUM_W-1:0]  div_quo;
    logic [PIX_W-1:0]  pick_mean;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign tap      = scan_out[0];

    // effective geometry
    always_comb
    begin
        if (int'(radius_reg) > MAX_RADIUS)
        begin
            r_eff = RW'(MAX_RADIUS);
        end
        else
        begin
            r_eff = RW'(radius_reg);
        end
        if (line_width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (int'(line_width_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(line_width_reg);
        end
        h_eff = (frame_height_reg == '0) ? FH_W'(1) : frame_height_reg;
    end

    // position tests for the current item
    always_comb
    begin
        col_wrap  = ((WW+1)'(col_reg) + (WW+1)'(1)) >= (WW+1)'(w_eff);
        row_wrap  = ((FH_W+1)'(row_reg) + (FH_W+1)'(1)) >= (FH_W+1)'(h_eff);
        center_ok = (int'(col_reg) >= 2 * int'(r_eff)) && (int'(row_reg) >= 2 * int'(r_eff));
    end

    // new column: incoming pixel on top, older rows from the line store
    always_comb
    begin
        int src;
        row_in[0] = pix_reg;
        for (int a = 1; a < WIN; a++)
        begin
            src = int'(slot_reg) - a;
            if (src < 0)
            begin
                src = src + SLOTS;
            end
            row_in[a] = ram_rdata[SLW'(src)];
        end
    end

    // line store, one RAM per stored row
    for (genvar j = 0; j < SLOTS; j++)
    begin : g_line
        kgf_ram #(
            .WIDTH(PIX_W),
            .DEPTH(MAX_WIDTH)
        ) u_line_ram (
            .clk   (clk),
            .we    (ram_we && (slot_reg == SLW'(j))),
            .waddr (col_reg),
            .wdata (pix_reg),
            .re    (accept),
            .raddr (col_reg),
            .rdata (ram_rdata[j])
        );
    end

    // window row cells, scan chain closed into a ring
    for (genvar a = 0; a < WIN; a++)
    begin : g_row
        kgf_cell #(
            .WIN(WIN)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .pix_in   (row_in[a]),
            .scan_in  (scan_out[(a + 1) % WIN]),
            .scan_out (scan_out[a])
        );
    end

    // shared divider for the quadrant means
    kgf_div #(
        .DVD_W(SUM_W),
        .DSR_W(NW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg[q_idx_reg]),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // quadrant membership of the scanned element
    always_comb
    begin
        logic lo_a, hi_a, lo_b, hi_b;
        lo_a = int'(a_cnt_reg) <= int'(r_eff);
        hi_a = (int'(a_cnt_reg) >= int'(r_eff)) && (int'(a_cnt_reg) <= 2 * int'(r_eff));
        lo_b = int'(b_cnt_reg) <= int'(r_eff);
        hi_b = (int'(b_cnt_reg) >= int'(r_eff)) && (int'(b_cnt_reg) <= 2 * int'(r_eff));
        qmask[0] = hi_a && hi_b;
        qmask[1] = lo_a && hi_b;
        qmask[2] = hi_a && lo_b;
        qmask[3] = lo_a && lo_b;
        pass_last = (a_cnt_reg == AW'(WIN - 1)) && (b_cnt_reg == AW'(WIN - 1));
    end

    // least dispersion, later quadrant wins a tie
    always_comb
    begin
        logic [DSP_W-1:0] best;
        best      = disp_reg[0];
        pick_mean = mean_reg[0];
        for (int q = 1; q < NQUAD; q++)
        begin
            if (disp_reg[q] <= best)
            begin
                best      = disp_reg[q];
                pick_mean = mean_reg[q];
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_tvalid) state_next = ST_SHIFT;
            ST_SHIFT:     state_next = center_ok ? ST_LOAD : ST_OUT;
            ST_LOAD:      state_next = ST_SUM;
            ST_SUM:       if (pass_last) state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = (q_idx_reg == QUAD_LAST) ? ST_DISP : ST_DIV_START;
                end
            end
            ST_DISP:      if (pass_last) state_next = ST_PICK;
            ST_PICK:      state_next = ST_OUT;
            ST_OUT:       if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready         = 1'b0;
        cell_ctrl.shift  = 1'b0;
        cell_ctrl.load   = 1'b0;
        cell_ctrl.rotate = 1'b0;
        ram_we           = 1'b0;
        div_start        = 1'b0;
        case (state_reg)
            ST_IDLE:      s_tready = 1'b1;
            ST_SHIFT:
            begin
                cell_ctrl.shift = 1'b1;
                ram_we          = 1'b1;
            end
            ST_LOAD:      cell_ctrl.load = 1'b1;
            ST_SUM:       cell_ctrl.rotate = 1'b1;
            ST_DIV_START: div_start = 1'b1;
            ST_DISP:      cell_ctrl.rotate = 1'b1;
            default:      s_tready = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            radius_reg       <= RADIUS_RESET;
            line_width_reg   <= LW_RESET;
            frame_height_reg <= FH_RESET;
            col_reg          <= '0;
            row_reg          <= '0;
            slot_reg         <= '0;
            a_cnt_reg        <= '0;
            b_cnt_reg        <= '0;
            q_idx_reg        <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // config writes
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_RADIUS:       radius_reg       <= cfg_data[RAD_W-1:0];
                    CFG_LINE_WIDTH:   line_width_reg   <= cfg_data[LW_W-1:0];
                    CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_W-1:0];
                    default:          radius_reg       <= radius_reg;
                endcase
            end

            // raster counters advance once the pixel is in the window
            if (state_reg == ST_SHIFT)
            begin
                if (col_wrap)
                begin
                    col_reg <= '0;
                    if (row_wrap)
                    begin
                        row_reg  <= '0;
                        slot_reg <= '0;
                    end
                    else
                    begin
                        row_reg  <= row_reg + 1'b1;
                        slot_reg <= (slot_reg == SLW'(SLOTS - 1)) ? '0 : slot_reg + 1'b1;
                    end
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end

            // scan position, row major over the snapshot
            if (state_reg == ST_LOAD)
            begin
                a_cnt_reg <= '0;
                b_cnt_reg <= '0;
            end
            else if (cell_ctrl.rotate)
            begin
                if (b_cnt_reg == AW'(WIN - 1))
                begin
                    b_cnt_reg <= '0;
                    a_cnt_reg <= (a_cnt_reg == AW'(WIN - 1)) ? '0 : a_cnt_reg + 1'b1;
                end
                else
                begin
                    b_cnt_reg <= b_cnt_reg + 1'b1;
                end
            end

            // quadrant being divided
            if (state_reg == ST_LOAD)
            begin
                q_idx_reg <= '0;
            end
            else if ((state_reg == ST_DIV_WAIT) && div_done)
            begin
                q_idx_reg <= q_idx_reg + 1'b1;
            end

            // output register
            if ((state_reg == ST_OUT) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        logic [RW:0]    rp1;
        logic [PIX_W-1:0] diff;
        logic [2*PIX_W-1:0] sq;
        rp1 = (RW+1)'(r_eff) + (RW+1)'(1);

        if (accept)
        begin
            pix_reg <= s_tdata;
        end

        // center coordinates and flags of this item
        if (state_reg == ST_SHIFT)
        begin
            res_valid_reg <= center_ok;
            res_mean_reg  <= '0;
            res_ccol_reg  <= CCOL_W'(col_reg) - CCOL_W'(r_eff);
            res_crow_reg  <= row_reg - CROW_W'(r_eff);
            res_last_reg  <= col_wrap && row_wrap;
        end

        if (state_reg == ST_LOAD)
        begin
            n_reg <= NW'(rp1) * NW'(rp1);
            for (int q = 0; q < NQUAD; q++)
            begin
                sum_reg[q] <= '0;
            end
        end

        // sum pass
        if (state_reg == ST_SUM)
        begin
            for (int q = 0; q < NQUAD; q++)
            begin
                if (qmask[q])
                begin
                    sum_reg[q] <= sum_reg[q] + SUM_W'(tap);
                end
            end
        end

        if ((state_reg == ST_DIV_WAIT) && div_done)
        begin
            mean_reg[q_idx_reg] <= div_quo[PIX_W-1:0];
            for (int q = 0; q < NQUAD; q++)
            begin
                disp_reg[q] <= '0;
            end
        end

        // dispersion pass, one squarer per quadrant
        if (state_reg == ST_DISP)
        begin
            for (int q = 0; q < NQUAD; q++)
            begin
                diff = (tap >= mean_reg[q]) ? (tap - mean_reg[q]) : (mean_reg[q] - tap);
                sq   = diff * diff;
                if (qmask[q])
                begin
                    disp_reg[q] <= disp_reg[q] + DSP_W'(sq);
                end
            end
        end

        if (state_reg == ST_PICK)
        begin
            res_mean_reg <= pick_mean;
        end

        if ((state_reg == ST_OUT) && out_free)
        begin
            out_data_reg <= {2'b00, res_crow_reg, res_ccol_reg, res_mean_reg};
            out_user_reg <= res_valid_reg;
            out_last_reg <= res_last_reg;
        end
    end

    assign cfg_ready  = 1'b1;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_user_reg;
    assign m_tlast    = out_last_reg;

    `KGF_ASSERT(a_accept_shift, (s_tvalid && s_tready) |=> (state_reg == ST_SHIFT), "accepted pixel did not enter the window")
    `KGF_ASSERT(a_out_from_fsm, $rose(m_tvalid) |-> $past(state_reg == ST_OUT), "result appeared outside output state")
    `KGF_ASSERT(a_border_zero, (m_tvalid && !m_tuser[0]) |-> (m_tdata[7:0] == 8'd0), "border result carries nonzero value")
    `KGF_ASSERT_RST(a_reset_quiet, !rst_n |=> (!m_tvalid && (state_reg == ST_IDLE)), "output or sequencer active in reset")

endmodule

// ===== test/kuwahara_gray_filter_tb.sv =====
// Self-checking testbench for kuwahara_gray_filter: pixel streams against an in-bench predictor.
// Depends on kgf_pkg and the kuwahara_gray_filter RTL; reads no files.
module kuwahara_gray_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kgf_pkg::*;

    localparam int MAXW = 1024;
    localparam int MAXR = 4;
    localparam int SLOTS = 2 * MAXR;
    localparam int WIN = 2 * MAXR + 1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        logic [7:0]  value;
        logic        valid;
        logic [9:0]  ccol;
        logic [11:0] crow;
        logic        fend;
    } filt_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic s_tvalid;
    logic s_tready;
    logic [PIX_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0] m_tuser;
    logic m_tlast;

    // predictor state
    logic [7:0]  pixel_store [SLOTS][MAXW];
    logic [7:0]  win_px [WIN][WIN];
    int unsigned col_cnt, row_cnt;
    logic [2:0]  radius_reg;
    logic [10:0] width_reg;
    logic [11:0] height_reg;
    filt_result_t pending_results[$];

    int errors = 0;
    bit no_idle = 0;
    bit no_stall = 0;
    int stall_left = 0;

    kuwahara_gray_filter dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always #6 clk = ~clk;

    initial
    begin
        #40ms;
        $display("status: fail");
        $finish;
    end

    function automatic int unsigned eff_width(logic [10:0] w);
        if (w == 0)
            return 1;
        return (w > MAXW) ? MAXW : w;
    endfunction

    // mean and dispersion of one quadrant, corner (a0,b0) back from the newest pixel
    function automatic void quad_stats(int unsigned a0, int unsigned b0, int unsigned r,
                                       output int unsigned mean, output int unsigned disp);
        int unsigned sum, n, diff;
        sum = 0;
        disp = 0;
        n = (r + 1) * (r + 1);
        for (int unsigned a = a0; a <= a0 + r; a++)
            for (int unsigned b = b0; b <= b0 + r; b++)
                sum += win_px[a][b];
        mean = sum / n;
        for (int unsigned a = a0; a <= a0 + r; a++)
            for (int unsigned b = b0; b <= b0 + r; b++)
            begin
                diff = (win_px[a][b] >= mean) ? win_px[a][b] - mean : mean - win_px[a][b];
                disp += diff * diff;
            end
    endfunction

    // advance the filter model by one pixel and queue its result
    function automatic void predict_filter(logic [7:0] pix);
        int unsigned r, w, h, col, row, slot, m, d, best;
        int unsigned qa [4] = '{1, 0, 1, 0};
        int unsigned qb [4] = '{1, 1, 0, 0};
        bit col_wrap, row_wrap;
        filt_result_t res;
        r = (radius_reg > MAXR) ? MAXR : radius_reg;
        w = eff_width(width_reg);
        h = (height_reg == 0) ? 1 : height_reg;
        col = col_cnt % MAXW;
        row = row_cnt;
        for (int a = 0; a < WIN; a++)
            for (int b = WIN - 1; b > 0; b--)
                win_px[a][b] = win_px[a][b - 1];
        win_px[0][0] = pix;
        for (int a = 1; a < WIN; a++)
        begin
            slot = (row % SLOTS + SLOTS - a) % SLOTS;
            win_px[a][0] = pixel_store[slot][col];
        end
        pixel_store[row % SLOTS][col] = pix;

        res.valid = (col >= 2 * r) && (row >= 2 * r);
        res.value = '0;
        best = 0;
        if (res.valid)
            for (int q = 0; q < 4; q++)
            begin
                quad_stats(qa[q] * r, qb[q] * r, r, m, d);
                if (q == 0 || d <= best)
                begin
                    best = d;
                    res.value = m[7:0];
                end
            end
        col_wrap = (col + 1 >= w);
        row_wrap = (row + 1 >= h);
        res.ccol = 10'((col + 1024 - r) & 10'h3FF);
        res.crow = 12'((row + 4096 - r) & 12'hFFF);
        res.fend = col_wrap && row_wrap;
        pending_results.push_back(res);
        if (col_wrap)
        begin
            col_cnt = 0;
            row_cnt = row_wrap ? 0 : row + 1;
        end
        else
            col_cnt = col + 1;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result side: random stalls and comparison against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        filt_result_t want;
        int n;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else if (m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected transaction", m_tdata, 0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[7:0] !== want.value)
                    report_mismatch("filtered_value", m_tdata[7:0], want.value);
                if (m_tdata[17:8] !== want.ccol)
                    report_mismatch("center_column", m_tdata[17:8], want.ccol);
                if (m_tdata[29:18] !== want.crow)
                    report_mismatch("center_row", m_tdata[29:18], want.crow);
                if (m_tdata[31:30] !== 2'b00)
                    report_mismatch("tdata pad", m_tdata[31:30], 0);
                if (m_tuser[0] !== want.valid)
                    report_mismatch("center_valid", m_tuser[0], want.valid);
                if (m_tlast !== want.fend)
                    report_mismatch("frame_end", m_tlast, want.fend);
            end
            n = no_stall ? 0 : $urandom_range(0, 5);
            stall_left = n;
            m_tready <= (n == 0);
        end
        else if (stall_left > 0)
        begin
            m_tready <= (stall_left == 1);
            stall_left--;
        end
        else
            m_tready <= 1'b1;
    end

    // one pixel transaction; valid stays high into the next call when no gap follows
    task automatic send_pixel(logic [7:0] pix);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= pix;
        do @(posedge clk); while (!s_tready);
        predict_filter(pix);
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic stop_stream();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // register write while the block is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_drained();
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_RADIUS:       radius_reg = val[2:0];
            CFG_LINE_WIDTH:   width_reg = val[10:0];
            CFG_FRAME_HEIGHT: height_reg = val[11:0];
            default:          ;
        endcase
    endtask

    function automatic logic [7:0] draw_pixel(int mode, logic [7:0] base);
        case (mode)
            0: return 8'($urandom_range(0, 255));
            1: return base;
            2: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default: return 8'(int'(base) + $urandom_range(0, 6) - 3);
        endcase
    endfunction

    task automatic finish_frame();
        while (col_cnt != 0 || row_cnt != 0)
            send_pixel(8'($urandom_range(0, 255)));
        stop_stream();
    endtask

    // extremes, a 0/255 checkerboard where quadrants tie, radius zero pass-through
    task automatic test_directed();
        write_reg(CFG_RADIUS, 12'd1);
        write_reg(CFG_LINE_WIDTH, 12'd9);
        write_reg(CFG_FRAME_HEIGHT, 12'd9);
        write_reg(CFG_UNUSED, 12'hFFF);
        for (int i = 0; i < 18; i++)
            send_pixel(i[0] ? 8'd255 : 8'd0);
        for (int i = 0; i < 4; i++)
            send_pixel(8'd128);
        send_pixel(8'd0);
        send_pixel(8'd255);
        stop_stream();
        write_reg(CFG_RADIUS, 12'd0);
        send_pixel(8'd77);
        send_pixel(8'd255);
        send_pixel(8'd0);
        stop_stream();
    endtask

    // widest line with saturated width, one-pixel lines, one-row frames
    task automatic test_geometry_extremes();
        finish_frame();
        write_reg(CFG_RADIUS, 12'd1);
        write_reg(CFG_LINE_WIDTH, 12'd2047);
        write_reg(CFG_FRAME_HEIGHT, 12'd9);
        for (int i = 0; i < MAXW + 16; i++)
            send_pixel(8'($urandom_range(0, 255)));
        stop_stream();
        write_reg(CFG_FRAME_HEIGHT, 12'd4095);
        write_reg(CFG_LINE_WIDTH, 12'd0);
        write_reg(CFG_RADIUS, 12'd0);
        for (int i = 0; i < 20; i++)
            send_pixel(8'($urandom_range(0, 255)));
        stop_stream();
        write_reg(CFG_FRAME_HEIGHT, 12'd0);
        for (int i = 0; i < 10; i++)
            send_pixel(8'($urandom_range(0, 255)));
        stop_stream();
        write_reg(CFG_LINE_WIDTH, 12'd9);
        write_reg(CFG_FRAME_HEIGHT, 12'd9);
    endtask

    // random geometry and radius per phase; line width grows only at a frame start
    task automatic test_random_frames(int total);
        int sent, n, mode;
        int unsigned cur_w, new_w;
        logic [7:0] base;
        sent = 0;
        while (sent < total)
        begin
            write_reg(CFG_RADIUS, 12'($urandom_range(0, 7)));
            cur_w = eff_width(width_reg);
            new_w = $urandom_range(9, 24);
            if ((col_cnt != 0 || row_cnt != 0) && new_w > cur_w)
                new_w = cur_w;
            write_reg(CFG_LINE_WIDTH, 12'(new_w));
            write_reg(CFG_FRAME_HEIGHT, 12'($urandom_range(9, 16)));
            no_idle = ($urandom_range(0, 3) == 0);
            no_stall = ($urandom_range(0, 3) == 0);
            mode = $urandom_range(0, 3);
            base = 8'($urandom_range(3, 252));
            n = $urandom_range(40, 120);
            for (int i = 0; i < n; i++)
            begin
                if (i == n / 2 && $urandom_range(0, 2) == 0)
                begin
                    stop_stream();
                    wait_drained();
                end
                send_pixel(draw_pixel(mode, base));
            end
            stop_stream();
            sent += n;
        end
        no_idle = 0;
        no_stall = 0;
    endtask

    initial
    begin
        cfg_valid = 1'b0;
        cfg_index = CFG_RADIUS;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        for (int s = 0; s < SLOTS; s++)
            for (int c = 0; c < MAXW; c++)
                pixel_store[s][c] = '0;
        for (int a = 0; a < WIN; a++)
            for (int b = 0; b < WIN; b++)
                win_px[a][b] = '0;
        col_cnt = 0;
        row_cnt = 0;
        radius_reg = RADIUS_RESET;
        width_reg = LW_RESET;
        height_reg = FH_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_geometry_extremes();
        test_random_frames(200);

        stop_stream();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
